// ===== sv/rmd_pkg.sv =====
// shared widths, constants and stage payload types for the redmean distance block
`default_nettype none

package rmd_pkg;

  // channel and weight widths
  localparam int CW = 8;             // one color channel
  localparam int RSW = CW + 1;       // sum of two red channels
  localparam int WW = 11;            // red / blue weight, up to 1530
  localparam int SQW = 2 * CW;       // squared channel difference
  localparam int PW = 27;            // one weighted term, below 2^27
  localparam int SW = 29;            // weighted sum, below 2^29

  // square root datapath
  localparam int FRAC = 8;                 // fraction bits of the result
  localparam int ROOT_BITS = 17;           // bits of the root term
  localparam int RW = SW + 2 * FRAC;       // radicand, sum scaled by 2^16
  localparam int DW = 30;                  // running ROOT_K * q
  localparam int TW = 48;                  // trial subtrahend
  localparam int DIST_W = 17;              // result width

  // redmean weights in integer form
  localparam int WR_BASE = 1020;
  localparam int WB_BASE = 1530;
  localparam int G_WEIGHT = 2040;
  // 510 * 9, folds the mean weighting and the exact 1/3
  localparam int ROOT_K = 4590;

  typedef struct packed {
    logic [CW-1:0] da;
    logic [SW-1:0] s;
  } front_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DW-1:0] d;
    logic [ROOT_BITS-1:0] q;
    logic [CW-1:0] da;
  } root_t;

endpackage

`default_nettype wire

// ===== sv/rmd_front.sv =====
// front end: channel differences, squares, weighting and the weighted sum over four stages
`default_nettype none

module rmd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               src_valid,
  output logic                    src_stall,
  input  wire logic [7:0]         first_red,
  input  wire logic [7:0]         first_green,
  input  wire logic [7:0]         first_blue,
  input  wire logic [7:0]         first_alpha,
  input  wire logic [7:0]         second_red,
  input  wire logic [7:0]         second_green,
  input  wire logic [7:0]         second_blue,
  input  wire logic [7:0]         second_alpha,
  output logic                    dst_valid,
  output rmd_pkg::front_t         dst_data,
  input  wire logic               dst_ready
);
  import rmd_pkg::*;

  logic [3:0] v;
  logic [3:0] en;

  // stage a: differences and red sum
  logic [CW-1:0]  a_dr, a_dg, a_db, a_da;
  logic [RSW-1:0] a_rsum;
  // stage b: squares and weights
  logic [SQW-1:0] b_dr2, b_dg2, b_db2;
  logic [WW-1:0]  b_wr, b_wb;
  logic [CW-1:0]  b_da;
  // stage c: weighted terms
  logic [PW-1:0]  c_pr, c_pg, c_pb;
  logic [CW-1:0]  c_da;
  // stage d: sum
  front_t         d_out;

  // a stage moves when it is empty or the next one moves
  assign en[3] = !v[3] || dst_ready;
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign en[0] = !v[0] || en[1];
  assign src_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= src_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_dr <= (first_red > second_red) ? first_red - second_red : second_red - first_red;
      a_dg <= (first_green > second_green) ? first_green - second_green
                                           : second_green - first_green;
      a_db <= (first_blue > second_blue) ? first_blue - second_blue
                                         : second_blue - first_blue;
      a_da <= (first_alpha > second_alpha) ? first_alpha - second_alpha
                                           : second_alpha - first_alpha;
      a_rsum <= RSW'(first_red) + RSW'(second_red);
    end
    if (en[1]) begin
      b_dr2 <= SQW'(a_dr) * SQW'(a_dr);
      b_dg2 <= SQW'(a_dg) * SQW'(a_dg);
      b_db2 <= SQW'(a_db) * SQW'(a_db);
      b_wr  <= WW'(WR_BASE) + WW'(a_rsum);
      b_wb  <= WW'(WB_BASE) - WW'(a_rsum);
      b_da  <= a_da;
    end
    if (en[2]) begin
      c_pr <= PW'(b_wr) * PW'(b_dr2);
      c_pg <= PW'(b_dg2) * PW'(G_WEIGHT);
      c_pb <= PW'(b_wb) * PW'(b_db2);
      c_da <= b_da;
    end
    if (en[3]) begin
      d_out.s  <= SW'(c_pr) + SW'(c_pg) + SW'(c_pb);
      d_out.da <= c_da;
    end
  end

  assign dst_valid = v[3];
  assign dst_data = d_out;

endmodule

`default_nettype wire

// ===== sv/rmd_root.sv =====
// pipelined restoring square root, one result bit per stage
`default_nettype none

module rmd_root (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  src_valid,
  output logic                       src_stall,
  input  wire rmd_pkg::front_t       src_data,
  output logic                       dst_valid,
  output logic [rmd_pkg::ROOT_BITS-1:0] dst_q,
  output logic [rmd_pkg::CW-1:0]     dst_da,
  input  wire logic                  dst_ready
);
  import rmd_pkg::*;

  root_t st  [ROOT_BITS];
  root_t src [ROOT_BITS];
  logic  v     [ROOT_BITS];
  logic  src_v [ROOT_BITS];
  logic  en    [ROOT_BITS];

  // radicand is the sum scaled by 2^16, nothing taken yet
  assign src[0].rem = {src_data.s, (2 * FRAC)'(0)};
  assign src[0].d   = '0;
  assign src[0].q   = '0;
  assign src[0].da  = src_data.da;
  assign src_v[0]   = src_valid;
  assign src_stall  = !en[0];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_bit
    localparam int B = ROOT_BITS - 1 - k;
    logic [TW-1:0] trial;
    logic [TW:0]   sub;
    logic          take;

    // K*(q+2^B)^2 - K*q^2 = (K*q << (B+1)) + (K << 2B)
    assign trial = (TW'(src[k].d) << (B + 1)) + (TW'(ROOT_K) << (2 * B));
    assign sub   = {1'b0, TW'(src[k].rem)} - {1'b0, trial};
    assign take  = !sub[TW];

    if (k == ROOT_BITS - 1) begin : g_last
      assign en[k] = !v[k] || dst_ready;
    end else begin : g_mid
      assign en[k] = !v[k] || en[k+1];
      assign src[k+1] = st[k];
      assign src_v[k+1] = v[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k].rem <= take ? sub[RW-1:0] : src[k].rem;
        st[k].d   <= take ? src[k].d + DW'(ROOT_K << B) : src[k].d;
        st[k].q   <= take ? (src[k].q | (ROOT_BITS'(1) << B)) : src[k].q;
        st[k].da  <= src[k].da;
      end
    end
  end

  assign dst_valid = v[ROOT_BITS-1];
  assign dst_q     = st[ROOT_BITS-1].q;
  assign dst_da    = st[ROOT_BITS-1].da;

endmodule

`default_nettype wire

// ===== sv/rgba_redmean_color_distance.sv =====
// top level: redmean rgba color distance, fully pipelined, one item per clock while not stalled
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  color    | color_valid, color_stall | first_/second_ red green blue alpha, 8 b
//  dist     | dist_valid, dist_stall   | distance, 17 b, 8 fraction bits
//
// one item enters per clock while color_stall is low; it reaches dist_valid through
// 22 register stages: 4 front, 17 square root, 1 output register
// the square root takes one result bit per stage, which sets the depth
// rst is synchronous and clears only the valid bits
// a stage moves whenever it is empty or its successor moves, so bubbles close up
// and color_stall rises only once every stage holds an item and dist is stalled
`default_nettype none

module rgba_redmean_color_distance (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        color_valid,
  output logic             color_stall,
  input  wire logic [7:0]  first_red,
  input  wire logic [7:0]  first_green,
  input  wire logic [7:0]  first_blue,
  input  wire logic [7:0]  first_alpha,
  input  wire logic [7:0]  second_red,
  input  wire logic [7:0]  second_green,
  input  wire logic [7:0]  second_blue,
  input  wire logic [7:0]  second_alpha,
  output logic             dist_valid,
  input  wire logic        dist_stall,
  output logic [16:0]      distance
);
  import rmd_pkg::*;

  // front end to root
  logic             fr_valid;
  logic             fr_stall;
  front_t           fr_data;
  // root to output register
  logic             rt_valid;
  logic             rt_stall;
  logic [ROOT_BITS-1:0] rt_q;
  logic [CW-1:0]    rt_da;
  logic             out_en;

  // s = (1020+r1+r2)*dr^2 + 2040*dg^2 + (1530-r1-r2)*db^2
  rmd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (color_valid),
    .src_stall    (color_stall),
    .first_red    (first_red),
    .first_green  (first_green),
    .first_blue   (first_blue),
    .first_alpha  (first_alpha),
    .second_red   (second_red),
    .second_green (second_green),
    .second_blue  (second_blue),
    .second_alpha (second_alpha),
    .dst_valid    (fr_valid),
    .dst_data     (fr_data),
    .dst_ready    (!fr_stall)
  );

  // q = largest value with 4590*q^2 <= s*2^16, i.e. 256*sqrt(s/510)/3 truncated
  rmd_root u_root (
    .clk       (clk),
    .rst       (rst),
    .src_valid (fr_valid),
    .src_stall (fr_stall),
    .src_data  (fr_data),
    .dst_valid (rt_valid),
    .dst_q     (rt_q),
    .dst_da    (rt_da),
    .dst_ready (!rt_stall)
  );

  // output register, the alpha term joins here
  assign out_en   = !dist_valid || !dist_stall;
  assign rt_stall = !out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (out_en) begin
      dist_valid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      distance <= DIST_W'({rt_da, FRAC'(0)}) + DIST_W'(rt_q);
    end
  end

endmodule

`default_nettype wire

// ===== sv/rmd_checker.sv =====
// port level checks for the redmean distance block and their binding
`default_nettype none

module rmd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        color_valid,
  input wire logic        color_stall,
  input wire logic        dist_valid,
  input wire logic        dist_stall,
  input wire logic [16:0] distance
);

  localparam logic [16:0] DIST_MAX = 17'd130560;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !dist_valid)
    else $error("dist_valid high after reset");

  // backpressure only reaches the input through a stalled full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    color_stall |-> (dist_valid && dist_stall))
    else $error("color_stall without a stalled result");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (dist_valid && dist_stall) |=> (dist_valid && $stable(distance)))
    else $error("stalled result changed");

  // 255 + 255 in 8-bit fixed point is the ceiling
  a_range: assert property (@(posedge clk) disable iff (rst)
    dist_valid |-> (distance <= DIST_MAX))
    else $error("distance out of range");

endmodule

bind rgba_redmean_color_distance rmd_checker u_rmd_checker (.*);

`default_nettype wire
